// File: rtl/slnf_pkg.sv
// Shared types, constants and number tables for the Lagrange node factor unit.
`timescale 1ns / 1ps
`default_nettype none

package slnf_pkg;

  localparam int unsigned MaxDegree = 8;
  localparam int unsigned PcW       = 4;

  localparam logic [1:0] DimReset = 2'd2;
  localparam logic [3:0] DegReset = 4'd2;

  // Register select, taken from paddr bit 2
  localparam logic RegDimension = 1'b0;
  localparam logic RegDegree    = 1'b1;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_NOP,
    OP_TET,
    OP_TRI,
    OP_FORM,
    OP_SCAN,
    OP_BAD
  } op_e;

  typedef struct packed {
    logic hold;
    logic bad;
    logic dim1;
    logic dim2;
  } seq_status_t;

  // k(k+1)/2; beyond the useful range a value above any 8-bit index
  function automatic logic [9:0] tri_num(input logic [3:0] k);
    logic [9:0] v;
    unique case (k)
      4'd0:    v = 10'd0;
      4'd1:    v = 10'd1;
      4'd2:    v = 10'd3;
      4'd3:    v = 10'd6;
      4'd4:    v = 10'd10;
      4'd5:    v = 10'd15;
      4'd6:    v = 10'd21;
      4'd7:    v = 10'd28;
      4'd8:    v = 10'd36;
      4'd9:    v = 10'd45;
      default: v = 10'h3FF;
    endcase
    return v;
  endfunction

  // k(k+1)(k+2)/6
  function automatic logic [9:0] tet_num(input logic [3:0] k);
    logic [9:0] v;
    unique case (k)
      4'd0:    v = 10'd0;
      4'd1:    v = 10'd1;
      4'd2:    v = 10'd4;
      4'd3:    v = 10'd10;
      4'd4:    v = 10'd20;
      4'd5:    v = 10'd35;
      4'd6:    v = 10'd56;
      4'd7:    v = 10'd84;
      4'd8:    v = 10'd120;
      4'd9:    v = 10'd165;
      default: v = 10'h3FF;
    endcase
    return v;
  endfunction

  // Number of nodes of a degree-deg element; dim and deg already clamped
  function automatic logic [9:0] node_count(input logic [1:0] dim, input logic [3:0] deg);
    logic [9:0] v;
    unique case (dim)
      2'd1:    v = {6'd0, deg} + 10'd1;
      2'd2:    v = tri_num(deg + 4'd1);
      default: v = tet_num(deg + 4'd1);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/slnf_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module slnf_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire slnf_pkg::seq_status_t status_i,
  output slnf_pkg::op_e             op_o
);

  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_BAD,
    J_DIM1,
    J_DIM2
  } jmp_e;

  typedef struct packed {
    slnf_pkg::op_e           op;
    jmp_e                    jmp;
    logic [slnf_pkg::PcW-1:0] target;
  } ucode_t;

  localparam logic [slnf_pkg::PcW-1:0] PcIdle = 4'd0;
  localparam logic [slnf_pkg::PcW-1:0] PcTet  = 4'd4;
  localparam logic [slnf_pkg::PcW-1:0] PcTri  = 4'd5;
  localparam logic [slnf_pkg::PcW-1:0] PcForm = 4'd6;
  localparam logic [slnf_pkg::PcW-1:0] PcBad  = 4'd8;
  localparam logic [slnf_pkg::PcW-1:0] PcLast = 4'd8;

  function automatic ucode_t ucode_rom(input logic [slnf_pkg::PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{op: slnf_pkg::OP_IDLE, jmp: J_NONE,   target: PcIdle};
      4'd1:    w = '{op: slnf_pkg::OP_NOP,  jmp: J_BAD,    target: PcBad};
      4'd2:    w = '{op: slnf_pkg::OP_NOP,  jmp: J_DIM1,   target: PcForm};
      4'd3:    w = '{op: slnf_pkg::OP_NOP,  jmp: J_DIM2,   target: PcTri};
      4'd4:    w = '{op: slnf_pkg::OP_TET,  jmp: J_NONE,   target: PcTet};
      4'd5:    w = '{op: slnf_pkg::OP_TRI,  jmp: J_NONE,   target: PcTri};
      4'd6:    w = '{op: slnf_pkg::OP_FORM, jmp: J_NONE,   target: PcForm};
      4'd7:    w = '{op: slnf_pkg::OP_SCAN, jmp: J_ALWAYS, target: PcIdle};
      4'd8:    w = '{op: slnf_pkg::OP_BAD,  jmp: J_ALWAYS, target: PcIdle};
      default: w = '{op: slnf_pkg::OP_NOP,  jmp: J_ALWAYS, target: PcIdle};
    endcase
    return w;
  endfunction

  logic [slnf_pkg::PcW-1:0] pc_q, pc_d;
  ucode_t                   word;
  logic                     take;

  assign word = ucode_rom(pc_q);
  assign op_o = word.op;

  always_comb begin
    unique case (word.jmp)
      J_NONE:   take = 1'b0;
      J_ALWAYS: take = 1'b1;
      J_BAD:    take = status_i.bad;
      J_DIM1:   take = status_i.dim1;
      J_DIM2:   take = status_i.dim2;
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (status_i.hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  property p_pc_in_program;
    @(posedge clk_i) disable iff (!rst_ni) pc_q <= PcLast;
  endproperty
  a_pc_in_program: assert property (p_pc_in_program)
    else $error("step counter left the program");

  property p_idle_holds_without_input;
    @(posedge clk_i) disable iff (!rst_ni)
      (pc_q == PcIdle && status_i.hold) |=> pc_q == PcIdle;
  endproperty
  a_idle_holds_without_input: assert property (p_idle_holds_without_input)
    else $error("sequencer left idle without an input word");

  property p_exit_to_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      ((word.op == slnf_pkg::OP_SCAN || word.op == slnf_pkg::OP_BAD) && !status_i.hold)
      |=> pc_q == PcIdle;
  endproperty
  a_exit_to_idle: assert property (p_exit_to_idle)
    else $error("sequencer did not return to idle after the final word");

endmodule

`default_nettype wire

// File: rtl/simplex_lagrange_node_factors_unit.sv
// Top level: configuration registers, node datapath and output register.
`timescale 1ns / 1ps
`default_nettype none

// Turns a Lagrange node number of a degree-N element on a segment, triangle or
// tetrahedron into its barycentric multi-index and emits one output word per
// selected pencil line, N words per node, the last one flagged and carrying the
// product of (N - offset). An out-of-range node number gives one word with last
// and bad_index set. One node at a time: after the input word is taken, a short
// microcode program runs on a small datapath: the accept, the dispatch words,
// the tetrahedral root search (dimension 3 only) and the triangular one
// (dimension 2 and 3), which find roots s3, s2 <= N, a step to form the index,
// then a scan over the pencil lines up to the last selected one, at most
// (dimension+1)(N+1) of them, which an output stall holds. The reset setting is
// a triangle with N = 2. The registers are dimension at address 0 and degree
// at address 4; zero is used as 1 and degrees above 8 as 8. Write them only
// while the unit is idle.
module simplex_lagrange_node_factors_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  node_index_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       bary_0_o,
  output logic [3:0]       bary_1_o,
  output logic [3:0]       bary_2_o,
  output logic [3:0]       bary_3_o,
  output logic [1:0]       line_face_o,
  output logic [2:0]       line_offset_o,
  output logic [24:0]      scale_product_o,
  output logic             last_o,
  output logic             bad_index_o
);

  // ---------------- configuration ----------------
  logic [1:0] cfg_dim_q;
  logic [3:0] cfg_deg_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dim_q <= slnf_pkg::DimReset;
      cfg_deg_q <= slnf_pkg::DegReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        slnf_pkg::RegDimension: cfg_dim_q <= pwdata[1:0];
        slnf_pkg::RegDegree:    cfg_deg_q <= pwdata[3:0];
        default:                cfg_dim_q <= cfg_dim_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      slnf_pkg::RegDimension: prdata = {30'd0, cfg_dim_q};
      slnf_pkg::RegDegree:    prdata = {28'd0, cfg_deg_q};
      default:                prdata = 32'd0;
    endcase
  end

  logic [1:0] dim_eff;
  logic [3:0] deg_eff;

  assign dim_eff = (cfg_dim_q == 2'd0) ? 2'd1 : cfg_dim_q;

  always_comb begin
    priority if (cfg_deg_q == 4'd0) begin
      deg_eff = 4'd1;
    end else if (cfg_deg_q > 4'(slnf_pkg::MaxDegree)) begin
      deg_eff = 4'(slnf_pkg::MaxDegree);
    end else begin
      deg_eff = cfg_deg_q;
    end
  end

  // ---------------- sequencer ----------------
  slnf_pkg::op_e         op;
  slnf_pkg::seq_status_t status;

  slnf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // ---------------- datapath ----------------
  logic [1:0]  dim_q;
  logic [3:0]  deg_q;
  logic [7:0]  r_q;
  logic [3:0]  k_q;
  logic [3:0]  s3_q;
  logic [3:0]  s2_q;
  logic [3:0]  b_q [4];
  logic [1:0]  c_q;
  logic [3:0]  a_q;
  logic [3:0]  e_q;
  logic [24:0] prod_q;

  logic        accept;
  logic        bad;
  logic        tet_more;
  logic        tri_more;
  logic [9:0]  tet_k;
  logic [9:0]  tri_k;
  logic        sel;
  logic        can_write;
  logic        last_hit;
  logic        scan_write;
  logic        bad_write;
  logic        line_end;
  logic [3:0]  fac;
  logic [24:0] prod_next;

  assign in_ready_o = (op == slnf_pkg::OP_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign bad      = {2'd0, r_q} >= slnf_pkg::node_count(dim_q, deg_q);
  assign tet_more = slnf_pkg::tet_num(k_q + 4'd1) <= {2'd0, r_q};
  assign tri_more = slnf_pkg::tri_num(k_q + 4'd1) <= {2'd0, r_q};
  assign tet_k    = slnf_pkg::tet_num(k_q);
  assign tri_k    = slnf_pkg::tri_num(k_q);

  assign can_write  = !out_valid_o || out_ready_i;
  assign sel        = a_q < b_q[c_q];
  assign last_hit   = ({1'b0, e_q} + 5'd1) == {1'b0, deg_q};
  assign scan_write = (op == slnf_pkg::OP_SCAN) && sel && can_write;
  assign bad_write  = (op == slnf_pkg::OP_BAD) && can_write;
  assign line_end   = (a_q == deg_q);
  assign fac        = deg_q - a_q;
  assign prod_next  = 25'(prod_q * {21'd0, fac});

  always_comb begin
    status.bad  = bad;
    status.dim1 = (dim_q == 2'd1);
    status.dim2 = (dim_q == 2'd2);
    unique case (op)
      slnf_pkg::OP_IDLE: status.hold = !in_valid_i;
      slnf_pkg::OP_TET:  status.hold = tet_more;
      slnf_pkg::OP_TRI:  status.hold = tri_more;
      slnf_pkg::OP_SCAN: status.hold = !(scan_write && last_hit);
      slnf_pkg::OP_BAD:  status.hold = !can_write;
      default:           status.hold = 1'b0;
    endcase
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (op)
      slnf_pkg::OP_IDLE: begin
        if (accept) begin
          dim_q <= dim_eff;
          deg_q <= deg_eff;
          r_q   <= node_index_i;
          k_q   <= 4'd0;
          s3_q  <= 4'd0;
          s2_q  <= 4'd0;
        end
      end
      slnf_pkg::OP_TET: begin
        if (tet_more) begin
          k_q <= k_q + 4'd1;
        end else begin
          s3_q <= k_q;
          r_q  <= r_q - tet_k[7:0];
          k_q  <= 4'd0;
        end
      end
      slnf_pkg::OP_TRI: begin
        if (tri_more) begin
          k_q <= k_q + 4'd1;
        end else begin
          s2_q <= k_q;
          r_q  <= r_q - tri_k[7:0];
          k_q  <= 4'd0;
        end
      end
      slnf_pkg::OP_FORM: begin
        unique case (dim_q)
          2'd1: begin
            b_q[0] <= r_q[3:0];
            b_q[1] <= deg_q - r_q[3:0];
            b_q[2] <= 4'd0;
            b_q[3] <= 4'd0;
          end
          2'd2: begin
            b_q[0] <= s2_q - r_q[3:0];
            b_q[1] <= r_q[3:0];
            b_q[2] <= deg_q - s2_q;
            b_q[3] <= 4'd0;
          end
          default: begin
            b_q[0] <= s3_q - s2_q;
            b_q[1] <= s2_q - r_q[3:0];
            b_q[2] <= r_q[3:0];
            b_q[3] <= deg_q - s3_q;
          end
        endcase
        c_q    <= 2'd0;
        a_q    <= 4'd0;
        e_q    <= 4'd0;
        prod_q <= 25'd1;
      end
      slnf_pkg::OP_SCAN: begin
        if (!sel || can_write) begin
          if (line_end) begin
            a_q <= 4'd0;
            c_q <= c_q + 2'd1;
          end else begin
            a_q <= a_q + 4'd1;
          end
        end
        if (scan_write) begin
          e_q    <= e_q + 4'd1;
          prod_q <= prod_next;
        end
      end
      default: begin
        r_q <= r_q;
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (scan_write || bad_write) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_write) begin
      bary_0_o        <= b_q[0];
      bary_1_o        <= b_q[1];
      bary_2_o        <= b_q[2];
      bary_3_o        <= b_q[3];
      line_face_o     <= c_q;
      line_offset_o   <= a_q[2:0];
      scale_product_o <= last_hit ? prod_next : 25'd0;
      last_o          <= last_hit;
      bad_index_o     <= 1'b0;
    end else if (bad_write) begin
      bary_0_o        <= 4'd0;
      bary_1_o        <= 4'd0;
      bary_2_o        <= 4'd0;
      bary_3_o        <= 4'd0;
      line_face_o     <= 2'd0;
      line_offset_o   <= 3'd0;
      scale_product_o <= 25'd0;
      last_o          <= 1'b1;
      bad_index_o     <= 1'b1;
    end
  end

  // ---------------- checks ----------------
  property p_bad_is_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && bad_index_o) |-> last_o;
  endproperty
  a_bad_is_last: assert property (p_bad_is_last)
    else $error("flagged word without last");

  property p_product_only_on_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !last_o) |-> scale_product_o == 25'd0;
  endproperty
  a_product_only_on_last: assert property (p_product_only_on_last)
    else $error("product shown on a word that is not last");

  property p_scan_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (op == slnf_pkg::OP_SCAN) |-> (c_q <= dim_q && e_q < deg_q);
  endproperty
  a_scan_in_range: assert property (p_scan_in_range)
    else $error("line scan ran past the last face or word count");

  property p_no_input_while_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (op == slnf_pkg::OP_SCAN || op == slnf_pkg::OP_BAD) |-> !in_ready_o;
  endproperty
  a_no_input_while_busy: assert property (p_no_input_while_busy)
    else $error("input taken while a node is still being emitted");

endmodule

`default_nettype wire
